FILE: src/ensc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register index codes and an arithmetic helper for the compensation core.
package ensc_pkg;

    localparam int DW = 32;

    typedef enum logic [2:0] {
        CFG_TEMP   = 3'd0,
        CFG_PRES_A = 3'd1,
        CFG_PRES_B = 3'd2,
        CFG_MIXED  = 3'd3,
        CFG_HUM    = 3'd4
    } t_cfg_idx;

    // Signed division by a power of two that truncates toward zero.
    function automatic logic signed [DW-1:0] sdiv(input logic signed [DW-1:0] x,
                                                   input logic [4:0] k);
        logic signed [DW-1:0] bias;
        bias = x[DW-1] ? $signed((DW'(1) << k) - DW'(1)) : '0;
        return (x + bias) >>> k;
    endfunction

endpackage

FILE: src/ensc_div_pipe.sv
`timescale 1ns / 1ps
// Pipelined unsigned restoring divider, one quotient bit per stage, with a sideband.
module ensc_div_pipe #(
    parameter int SIDE_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ensc_pkg::DW-1:0]     i_num,
    input  logic [ensc_pkg::DW-1:0]     i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [ensc_pkg::DW-1:0]     o_quot,
    output logic [SIDE_W-1:0]           o_side
);
    localparam int W = ensc_pkg::DW;

    logic         r_v    [0:W-1];
    logic [W-1:0] r_rem  [0:W-1];
    logic [W-1:0] r_num  [0:W-1];
    logic [W-1:0] r_quot [0:W-1];
    logic [W-1:0] r_den  [0:W-1];
    logic [SIDE_W-1:0] r_side [0:W-1];

    for (genvar g = 0; g < W; g++) begin : g_stage
        logic              v_in;
        logic [W-1:0]      rem_in, num_in, quot_in, den_in;
        logic [SIDE_W-1:0] side_in;
        logic [W:0]        trial;
        logic              ge;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign num_in  = i_num;
            assign quot_in = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign rem_in  = r_rem[g-1];
            assign num_in  = r_num[g-1];
            assign quot_in = r_quot[g-1];
            assign den_in  = r_den[g-1];
            assign side_in = r_side[g-1];
        end

        assign trial = {rem_in, num_in[W-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= v_in;
            end
            r_rem[g]  <= ge ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
            r_num[g]  <= num_in << 1;
            r_quot[g] <= {quot_in[W-2:0], ge};
            r_den[g]  <= den_in;
            r_side[g] <= side_in;
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quot  = r_quot[W-1];
    assign o_side  = r_side[W-1];

    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_v[W-1] && r_den[W-1] != '0) begin
            assert (r_rem[W-1] < r_den[W-1])
                else $error("divider remainder not below divisor");
        end
    end

endmodule

FILE: src/env_sensor_compensation_core.sv
`timescale 1ns / 1ps
// Environmental sensor compensation core: pipelined temperature, pressure and humidity path.
// An accepted start passes the arithmetic stages, the divider and the post-divider stages to the o_valid strobe.
// Throughput is one transaction per cycle; busy stays low and start may be held every cycle.
// The 32-stage pressure divider sets most of the latency; nine arithmetic stages lead into it.
// Synchronous active-low reset clears all valid bits and the calibration registers.
// The receiver cannot stall, so each result is shown for one cycle only.
module env_sensor_compensation_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [19:0]        i_raw_pressure,
    input  logic [19:0]        i_raw_temperature,
    input  logic [15:0]        i_raw_humidity,
    output logic               o_valid,
    output logic [16:0]        o_pressure_pa,
    output logic signed [10:0] o_temperature_deci_c,
    output logic [6:0]         o_humidity_percent,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    localparam int W      = ensc_pkg::DW;
    localparam int SIDE_W = 11 + W + 2;
    localparam int DIV_LAT = W + 3;

    typedef logic signed [W-1:0] t_s32;

    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_pres_a;
    logic [63:0] r_cal_pres_b;
    logic [47:0] r_cal_mixed;
    logic [39:0] r_cal_hum;

    t_s32 t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp   <= '0;
            r_cal_pres_a <= '0;
            r_cal_pres_b <= '0;
            r_cal_mixed  <= '0;
            r_cal_hum    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ensc_pkg::CFG_TEMP:   r_cal_temp   <= i_cfg_data[47:0];
                ensc_pkg::CFG_PRES_A: r_cal_pres_a <= i_cfg_data;
                ensc_pkg::CFG_PRES_B: r_cal_pres_b <= i_cfg_data;
                ensc_pkg::CFG_MIXED:  r_cal_mixed  <= i_cfg_data[47:0];
                ensc_pkg::CFG_HUM:    r_cal_hum    <= i_cfg_data[39:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        t1 = $signed({16'd0, r_cal_temp[15:0]});
        t2 = $signed({{16{r_cal_temp[31]}}, r_cal_temp[31:16]});
        t3 = $signed({{16{r_cal_temp[47]}}, r_cal_temp[47:32]});
        p1 = $signed({16'd0, r_cal_pres_a[15:0]});
        p2 = $signed({{16{r_cal_pres_a[31]}}, r_cal_pres_a[31:16]});
        p3 = $signed({{16{r_cal_pres_a[47]}}, r_cal_pres_a[47:32]});
        p4 = $signed({{16{r_cal_pres_a[63]}}, r_cal_pres_a[63:48]});
        p5 = $signed({{16{r_cal_pres_b[15]}}, r_cal_pres_b[15:0]});
        p6 = $signed({{16{r_cal_pres_b[31]}}, r_cal_pres_b[31:16]});
        p7 = $signed({{16{r_cal_pres_b[47]}}, r_cal_pres_b[47:32]});
        p8 = $signed({{16{r_cal_pres_b[63]}}, r_cal_pres_b[63:48]});
        p9 = $signed({{16{r_cal_mixed[15]}}, r_cal_mixed[15:0]});
        h1 = $signed({24'd0, r_cal_mixed[23:16]});
        h2 = $signed({{16{r_cal_mixed[39]}}, r_cal_mixed[39:24]});
        h3 = $signed({24'd0, r_cal_mixed[47:40]});
        h4 = $signed({{16{r_cal_hum[15]}}, r_cal_hum[15:0]});
        h5 = $signed({{16{r_cal_hum[31]}}, r_cal_hum[31:16]});
        h6 = $signed({{24{r_cal_hum[39]}}, r_cal_hum[39:32]});
    end

    logic        r_v [1:9];
    logic [19:0] r_adc_p [1:8];
    logic [15:0] r_adc_h [1:6];

    t_s32 r1_at, r1_bt;
    t_s32 r2_ma, r2_mb;
    t_s32 r3_a, r3_mb2;
    t_s32 r4_tf;
    t_s32 r5_t5, r5_pa, r5_ha;
    logic        r6_tneg;
    logic [13:0] r6_tabs;
    t_s32 r6_sq, r6_ap5, r6_ap2, r6_dh, r6_bh, r6_ch;
    logic        r7_tneg;
    logic [26:0] r7_tm;
    t_s32 r7_b, r7_c, r7_ap5x2, r7_d, r7_e1, r7_m;
    logic signed [10:0] r8_temp;
    t_s32 r8_bsum, r8_pm, r8_dm, r8_e1;
    logic signed [10:0] r9_temp;
    t_s32 r9_adiv, r9_cm;
    logic [W-1:0] r9_pres;

    t_s32 n6_tc, n6_q, n7_braw;
    logic [10:0] n8_tq;
    logic [W-1:0] n9_diff;

    always_comb begin
        n6_tc = ensc_pkg::sdiv(r5_t5 + 32'sd128, 5'd8);
        if (n6_tc < -32'sd4000) begin
            n6_tc = -32'sd4000;
        end else if (n6_tc > 32'sd8500) begin
            n6_tc = 32'sd8500;
        end
        n6_q    = ensc_pkg::sdiv(r5_pa, 5'd2);
        n7_braw = $signed({2'b00, r_adc_h[6], 14'd0});
        n8_tq   = r7_tm[26:16];
        n9_diff = W'(32'd1048576 - {12'd0, r_adc_p[8]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= 9; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            r_v[1] <= start && !busy;
            for (int i = 2; i <= 9; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end

        r_adc_p[1] <= i_raw_pressure;
        r_adc_h[1] <= i_raw_humidity;
        for (int i = 2; i <= 8; i++) begin
            r_adc_p[i] <= r_adc_p[i-1];
        end
        for (int i = 2; i <= 6; i++) begin
            r_adc_h[i] <= r_adc_h[i-1];
        end

        r1_at <= $signed({15'd0, i_raw_temperature[19:3]}) - (t1 <<< 1);
        r1_bt <= $signed({16'd0, i_raw_temperature[19:4]}) - t1;

        r2_ma <= r1_at * t2;
        r2_mb <= r1_bt * r1_bt;

        r3_a   <= ensc_pkg::sdiv(r2_ma, 5'd11);
        r3_mb2 <= ensc_pkg::sdiv(r2_mb, 5'd12) * t3;

        r4_tf <= r3_a + ensc_pkg::sdiv(r3_mb2, 5'd14);

        r5_t5 <= r4_tf * 32'sd5;
        r5_pa <= ensc_pkg::sdiv(r4_tf, 5'd1) - 32'sd64000;
        r5_ha <= r4_tf - 32'sd76800;

        r6_tneg <= n6_tc[W-1];
        r6_tabs <= n6_tc[W-1] ? 14'(-n6_tc) : n6_tc[13:0];
        r6_sq   <= n6_q * n6_q;
        r6_ap5  <= r5_pa * p5;
        r6_ap2  <= p2 * r5_pa;
        r6_dh   <= h5 * r5_ha;
        r6_bh   <= r5_ha * h6;
        r6_ch   <= r5_ha * h3;

        r7_tneg  <= r6_tneg;
        r7_tm    <= 27'(r6_tabs) * 27'd6554;
        r7_b     <= ensc_pkg::sdiv(r6_sq, 5'd11) * p6;
        r7_c     <= p3 * ensc_pkg::sdiv(r6_sq, 5'd13);
        r7_ap5x2 <= r6_ap5 <<< 1;
        r7_d     <= ensc_pkg::sdiv(r6_ap2, 5'd1);
        r7_e1    <= ensc_pkg::sdiv(n7_braw - (h4 <<< 20) - r6_dh + 32'sd16384, 5'd15);
        r7_m     <= ensc_pkg::sdiv(r6_bh, 5'd10)
                    * (ensc_pkg::sdiv(r6_ch, 5'd11) + 32'sd32768);

        r8_temp <= r7_tneg ? $signed(-n8_tq) : $signed(n8_tq);
        r8_bsum <= ensc_pkg::sdiv(r7_b + r7_ap5x2, 5'd2) + (p4 <<< 16);
        r8_pm   <= (32'sd32768 + ensc_pkg::sdiv(ensc_pkg::sdiv(r7_c, 5'd3) + r7_d, 5'd18))
                   * p1;
        r8_dm   <= (ensc_pkg::sdiv(r7_m, 5'd10) + 32'sd2097152) * h2;
        r8_e1   <= r7_e1;

        r9_temp <= r8_temp;
        r9_adiv <= ensc_pkg::sdiv(r8_pm, 5'd15);
        r9_pres <= (n9_diff - W'(ensc_pkg::sdiv(r8_bsum, 5'd12))) * 32'd3125;
        r9_cm   <= r8_e1 * ensc_pkg::sdiv(r8_dm + 32'sd8192, 5'd14);
    end

    logic              d_valid;
    logic [W-1:0]      d_quot;
    logic [SIDE_W-1:0] d_side;
    logic [W-1:0]      div_num;

    assign div_num = r9_pres[W-1] ? r9_pres : (r9_pres << 1);

    ensc_div_pipe #(
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[9]),
        .i_num   (div_num),
        .i_den   (r9_adiv),
        .i_side  ({r9_temp, r9_cm, r9_pres[W-1], r9_adiv == '0}),
        .o_valid (d_valid),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    logic signed [10:0] d_temp;
    t_s32               d_cm, n1_hq;
    logic               d_dbl, d_zero;
    logic [W-1:0]       n1_q;

    assign d_temp = d_side[SIDE_W-1 -: 11];
    assign d_cm   = d_side[W+1:2];
    assign d_dbl  = d_side[1];
    assign d_zero = d_side[0];
    assign n1_q   = d_dbl ? (d_quot << 1) : d_quot;
    assign n1_hq  = ensc_pkg::sdiv(d_cm, 5'd15);

    logic               r_p1_v, r_p2_v;
    logic signed [10:0] r_p1_temp, r_p2_temp;
    logic               r_p1_zero, r_p2_zero;
    logic [W-1:0]       r_p1_q, r_p2_q, r_p1_sq;
    t_s32               r_p1_dm, r_p1_cm, r_p1_hq, r_p2_cm, r_p2_c, r_p2_d, r_p2_dd;

    t_s32         n3_sum, n3_e;
    logic [W-1:0] n3_p;

    always_comb begin
        n3_sum = ensc_pkg::sdiv(r_p2_c, 5'd12) + r_p2_d + p7;
        n3_p   = r_p2_q + W'(ensc_pkg::sdiv(n3_sum, 5'd4));
        if (r_p2_zero || n3_p < 32'd30000) begin
            n3_p = 32'd30000;
        end else if (n3_p > 32'd110000) begin
            n3_p = 32'd110000;
        end
        n3_e = r_p2_cm - ensc_pkg::sdiv(r_p2_dd, 5'd4);
        if (n3_e < 32'sd0) begin
            n3_e = 32'sd0;
        end else if (n3_e > 32'sd419430400) begin
            n3_e = 32'sd419430400;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_p1_v  <= d_valid;
            r_p2_v  <= r_p1_v;
            o_valid <= r_p2_v;
        end

        r_p1_temp <= d_temp;
        r_p1_zero <= d_zero;
        r_p1_q    <= n1_q;
        r_p1_sq   <= (n1_q >> 3) * (n1_q >> 3);
        r_p1_dm   <= $signed(n1_q >> 2) * p8;
        r_p1_cm   <= d_cm;
        r_p1_hq   <= n1_hq * n1_hq;

        r_p2_temp <= r_p1_temp;
        r_p2_zero <= r_p1_zero;
        r_p2_q    <= r_p1_q;
        r_p2_c    <= p9 * $signed(r_p1_sq >> 13);
        r_p2_d    <= ensc_pkg::sdiv(r_p1_dm, 5'd13);
        r_p2_cm   <= r_p1_cm;
        r_p2_dd   <= ensc_pkg::sdiv(r_p1_hq, 5'd7) * h1;

        o_temperature_deci_c <= r_p2_temp;
        o_pressure_pa        <= n3_p[16:0];
        o_humidity_percent   <= n3_e[28:22];
    end

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[9] |-> ##DIV_LAT o_valid)
        else $error("result strobe missing after pipeline latency");

    a_pres: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pressure_pa >= 17'd30000 && o_pressure_pa <= 17'd110000))
        else $error("pressure out of saturation range");

    a_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_deci_c >= -11'sd400 && o_temperature_deci_c <= 11'sd850))
        else $error("temperature out of saturation range");

    a_hum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_humidity_percent <= 7'd100)
        else $error("humidity out of saturation range");

endmodule
